/* hw/rtl/mer_pkg.sv */
// Shared widths, sequencer states and flag types for the midpoint ellipse rasterizer.
package mer_pkg;

	localparam int COORD_BITS  = 12;
	localparam int RADIUS_BITS = 11;
	localparam int OUT_W       = 14;
	localparam int DEC_W       = 48;
	localparam int SQ_W        = 2 * RADIUS_BITS;
	localparam int PROD_W      = 2 * SQ_W;

	localparam logic [RADIUS_BITS-1:0] X_MAX = {RADIUS_BITS{1'b1}};

	typedef enum logic [20:0] {
		ST_IDLE = 21'b000000000000000000001,
		ST_SQX  = 21'b000000000000000000010,
		ST_SQY  = 21'b000000000000000000100,
		ST_RXY  = 21'b000000000000000001000,
		ST_INIT = 21'b000000000000000010000,
		ST_CMPA = 21'b000000000000000100000,
		ST_CMPB = 21'b000000000000001000000,
		ST_CMP  = 21'b000000000000010000000,
		ST_E1   = 21'b000000000000100000000,
		ST_E2   = 21'b000000000001000000000,
		ST_E3   = 21'b000000000010000000000,
		ST_E4   = 21'b000000000100000000000,
		ST_E5   = 21'b000000001000000000000,
		ST_E6   = 21'b000000010000000000000,
		ST_E7   = 21'b000000100000000000000,
		ST_BR2  = 21'b000001000000000000000,
		ST_UPDX = 21'b000010000000000000000,
		ST_UPDY = 21'b000100000000000000000,
		ST_UPDZ = 21'b001000000000000000000,
		ST_EMIT = 21'b010000000000000000000,
		ST_SPARE = 21'b100000000000000000000
	} mer_state_t;

	localparam logic MODE_START = 1'b0;
	localparam logic MODE_STEP  = 1'b1;

	// Which terms the decision update after a branch takes.
	typedef struct packed {
		logic add_x;
		logic sub_y;
	} mer_upd_t;

endpackage

/* hw/rtl/midpoint_ellipse_rasterizer_top.sv */
// Midpoint ellipse rasterizer: sequencer around one shared multiplier.
// From accepted beat to result: start runs SQX, SQY, RXY, INIT, EMIT; inactive
// step goes to EMIT; region-one step CMPA, CMPB, CMP, UPDX, UPDY, UPDZ, EMIT;
// region two BR2 then UPDX to EMIT; entering it, CMPA to CMP, E1 to E7, BR2 on.
// One item at a time; the next beat can come in the cycle after the result loads.
// arst_n clears the sequencer, the walk state and the output valid at once.
module midpoint_ellipse_rasterizer_top import mer_pkg::*; (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          mode,
	input  logic [COORD_BITS-1:0]         center_x,
	input  logic [COORD_BITS-1:0]         center_y,
	input  logic [RADIUS_BITS-1:0]        radius_x,
	input  logic [RADIUS_BITS-1:0]        radius_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          valid_res,
	output logic signed [OUT_W-1:0]       x_plus,
	output logic signed [OUT_W-1:0]       x_minus,
	output logic signed [OUT_W-1:0]       y_plus,
	output logic signed [OUT_W-1:0]       y_minus,
	output logic                          last
);

	mer_state_t state_q;

	// Walk state.
	logic [RADIUS_BITS-1:0]   x_q, y_q;
	logic signed [DEC_W-1:0]  dec_q;
	logic                     reg2_q;
	logic                     active_q;
	logic                     nul_q;
	mer_upd_t                 upd_q;

	// Held item and derived squares.
	logic [COORD_BITS-1:0]    cx_q, cy_q;
	logic [RADIUS_BITS-1:0]   rx_q, ry_q;
	logic [SQ_W-1:0]          rx2_q, ry2_q;

	// Shared multiplier: operands picked by state, product registered.
	logic [SQ_W-1:0]          mul_a, mul_b;
	logic [PROD_W-1:0]        p_q;
	logic [PROD_W-1:0]        t_q;
	logic signed [DEC_W-1:0]  p_dec;
	logic [SQ_W-1:0]          base;
	logic [RADIUS_BITS-1:0]   x_inc;
	logic [RADIUS_BITS-1:0]   y_m1;
	logic signed [DEC_W-1:0]  ent_sum;

	// Output register.
	logic                     out_valid_q;
	logic                     res_valid_q;
	logic [OUT_W-1:0]         xp_q, xm_q, yp_q, ym_q;
	logic                     last_q;

	logic in_acc;
	logic out_free;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign x_inc   = (x_q == X_MAX) ? x_q : x_q + 1'b1;   // saturate at the top
	assign y_m1    = y_q - 1'b1;
	assign p_dec   = DEC_W'(p_q);
	assign base    = reg2_q ? rx2_q : ry2_q;
	assign ent_sum = dec_q - p_dec;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_SQX: begin
				mul_a = SQ_W'(rx_q);
				mul_b = SQ_W'(rx_q);
			end
			ST_SQY: begin
				mul_a = SQ_W'(ry_q);
				mul_b = SQ_W'(ry_q);
			end
			ST_RXY: begin
				mul_a = rx2_q;
				mul_b = SQ_W'(ry_q);
			end
			ST_CMPA, ST_UPDX: begin
				mul_a = ry2_q;
				mul_b = SQ_W'(x_q);
			end
			ST_CMPB, ST_UPDY: begin
				mul_a = rx2_q;
				mul_b = SQ_W'(y_q);
			end
			ST_E1: begin
				mul_a = SQ_W'(x_q);
				mul_b = SQ_W'(x_q);
			end
			ST_E2: begin
				mul_a = SQ_W'(y_m1);
				mul_b = SQ_W'(y_m1);
			end
			ST_E3: begin
				mul_a = ry2_q;
				mul_b = t_q[SQ_W-1:0];
			end
			ST_E4: begin
				mul_a = rx2_q;
				mul_b = t_q[SQ_W-1:0];
			end
			ST_E5: begin
				mul_a = rx2_q;
				mul_b = ry2_q;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			x_q         <= '0;
			y_q         <= '0;
			dec_q       <= '0;
			reg2_q      <= 1'b0;
			active_q    <= 1'b0;
			nul_q       <= 1'b0;
			upd_q       <= '0;
			cx_q        <= '0;
			cy_q        <= '0;
			rx_q        <= '0;
			ry_q        <= '0;
			rx2_q       <= '0;
			ry2_q       <= '0;
			t_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// Load the output beat from EMIT; otherwise drop it once taken.
			if ((state_q == ST_EMIT) && out_free)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						if (mode == MODE_START) begin
							// Load a new ellipse; any running walk is dropped.
							cx_q    <= center_x;
							cy_q    <= center_y;
							rx_q    <= radius_x;
							ry_q    <= radius_y;
							x_q     <= '0;
							y_q     <= radius_y;
							reg2_q  <= 1'b0;
							nul_q   <= 1'b0;
							state_q <= ST_SQX;
						end else if (!active_q) begin
							nul_q   <= 1'b1;
							state_q <= ST_EMIT;
						end else begin
							nul_q   <= 1'b0;
							state_q <= reg2_q ? ST_BR2 : ST_CMPA;
						end
					end
				end
				ST_SQX: state_q <= ST_SQY;
				ST_SQY: begin
					rx2_q   <= p_q[SQ_W-1:0];
					state_q <= ST_RXY;
				end
				ST_RXY: begin
					ry2_q   <= p_q[SQ_W-1:0];
					state_q <= ST_INIT;
				end
				ST_INIT: begin
					// ry^2 - rx^2*ry + floor(rx^2/4)
					dec_q   <= DEC_W'(ry2_q) + DEC_W'(rx2_q >> 2) - p_dec;
					state_q <= ST_EMIT;
				end
				ST_CMPA: state_q <= ST_CMPB;
				ST_CMPB: begin
					t_q     <= p_q;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					// Region one holds while ry^2*x <= rx^2*y.
					if (t_q <= p_q) begin
						x_q         <= x_inc;
						upd_q.add_x <= 1'b1;
						upd_q.sub_y <= !dec_q[DEC_W-1];
						if (!dec_q[DEC_W-1])
							y_q <= y_m1;
						state_q <= ST_UPDX;
					end else begin
						reg2_q  <= 1'b1;
						state_q <= ST_E1;
					end
				end
				ST_E1: state_q <= ST_E2;
				ST_E2: begin
					t_q     <= PROD_W'(p_q[SQ_W-1:0]) + PROD_W'(x_q);
					state_q <= ST_E3;
				end
				ST_E3: begin
					t_q     <= p_q;
					state_q <= ST_E4;
				end
				ST_E4: begin
					dec_q   <= p_dec + DEC_W'(ry2_q >> 2);
					state_q <= ST_E5;
				end
				ST_E5: begin
					dec_q   <= dec_q + p_dec;
					state_q <= ST_E6;
				end
				ST_E6: begin
					dec_q   <= ent_sum;
					state_q <= ST_E7;
				end
				ST_E7: begin
					// Truncate the half-step term toward zero.
					if (dec_q[DEC_W-1] && (ry2_q[1:0] != 2'b00))
						dec_q <= dec_q + DEC_W'(1);
					state_q <= ST_BR2;
				end
				ST_BR2: begin
					y_q         <= y_m1;
					upd_q.sub_y <= 1'b1;
					if (dec_q[DEC_W-1] || (dec_q == '0)) begin
						x_q         <= x_inc;
						upd_q.add_x <= 1'b1;
					end else begin
						upd_q.add_x <= 1'b0;
					end
					state_q <= ST_UPDX;
				end
				ST_UPDX: begin
					dec_q   <= dec_q + DEC_W'(base);
					state_q <= ST_UPDY;
				end
				ST_UPDY: begin
					if (upd_q.add_x)
						dec_q <= dec_q + (p_dec <<< 1);
					state_q <= ST_UPDZ;
				end
				ST_UPDZ: begin
					if (upd_q.sub_y)
						dec_q <= dec_q - (p_dec <<< 1);
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					// Hold until the output register is free; the beat loads above.
					if (out_free) begin
						if (!nul_q)
							active_q <= (y_q != '0);
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Output payload; no reset needed, qualified by out_valid_q.
	always_ff @(posedge clk) begin
		if ((state_q == ST_EMIT) && out_free) begin
			if (nul_q) begin
				res_valid_q <= 1'b0;
				xp_q        <= '0;
				xm_q        <= '0;
				yp_q        <= '0;
				ym_q        <= '0;
				last_q      <= 1'b0;
			end else begin
				res_valid_q <= 1'b1;
				xp_q        <= OUT_W'(cx_q) + OUT_W'(x_q);
				xm_q        <= OUT_W'(cx_q) - OUT_W'(x_q);
				yp_q        <= OUT_W'(cy_q) + OUT_W'(y_q);
				ym_q        <= OUT_W'(cy_q) - OUT_W'(y_q);
				last_q      <= (y_q == '0);
			end
		end
	end

	assign out_valid = out_valid_q;
	assign valid_res = res_valid_q;
	assign x_plus    = xp_q;
	assign x_minus   = xm_q;
	assign y_plus    = yp_q;
	assign y_minus   = ym_q;
	assign last      = last_q;

	// A run never walks past its vertical radius.
	a_y_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		y_q <= ry_q)
		else $error("vertical offset above held radius");

	// A closing beat on the output means the run is over.
	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && res_valid_q && last_q) |-> !active_q)
		else $error("run still active after last beat");

	// Region two is left only by accepting a start beat.
	a_reg2_exit: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(reg2_q) |-> $past(in_acc && (mode == MODE_START)))
		else $error("region two left without a start");

endmodule

/* dv/midpoint_ellipse_rasterizer_top_tb.sv */
// Self-checking testbench for the midpoint ellipse rasterizer top level.
`timescale 1ns / 1ps

module midpoint_ellipse_rasterizer_top_tb;
	import mer_pkg::*;

	// Generous ceiling for ~1000 beats, even in the slowest phase.
	localparam int CYCLE_LIMIT = 400000;
	// Settle time after the last point.
	localparam int DRAIN_CYCLES = 40;
	localparam int RANDOM_BEATS = 900;

	// One result beat: the four mirrored coordinates plus flags.
	typedef struct packed {
		logic             valid_res;
		logic [OUT_W-1:0] x_plus;
		logic [OUT_W-1:0] x_minus;
		logic [OUT_W-1:0] y_plus;
		logic [OUT_W-1:0] y_minus;
		logic             last;
	} point_t;

	// Tracks the ellipse walk and the points still owed by the block.
	class ellipse_scoreboard;
		logic [RADIUS_BITS-1:0] step_x;
		logic [RADIUS_BITS-1:0] step_y;
		longint                 dterm;
		bit                     second_half;
		bit                     walking;
		logic [COORD_BITS-1:0]  cx;
		logic [COORD_BITS-1:0]  cy;
		logic [RADIUS_BITS-1:0] rx;
		logic [RADIUS_BITS-1:0] ry;
		point_t                 pending_points[$];
		int                     mismatches;

		function new();
			step_x = '0;
			step_y = '0;
			dterm = 0;
			second_half = 0;
			walking = 0;
			cx = '0;
			cy = '0;
			rx = '0;
			ry = '0;
			mismatches = 0;
		endfunction

		// Append a point to the tail of the owed list.
		function void owe_point(point_t p);
			pending_points.insert(pending_points.size(), p);
		endfunction

		function void bump_x();
			if (step_x != X_MAX)
				step_x++;
		endfunction

		// Mirror the current offset around the held center; finish the run at y = 0.
		function point_t plot();
			point_t p;
			longint s;
			p.valid_res = 1'b1;
			s = longint'(cx) + longint'(step_x);
			p.x_plus = s[OUT_W-1:0];
			s = longint'(cx) - longint'(step_x);
			p.x_minus = s[OUT_W-1:0];
			s = longint'(cy) + longint'(step_y);
			p.y_plus = s[OUT_W-1:0];
			s = longint'(cy) - longint'(step_y);
			p.y_minus = s[OUT_W-1:0];
			p.last = (step_y == '0);
			if (step_y == '0)
				walking = 0;
			return p;
		endfunction

		function void advance();
			longint a2;
			longint b2;
			longint x;
			longint y;
			longint whole;
			a2 = longint'(rx) * longint'(rx);
			b2 = longint'(ry) * longint'(ry);
			x = longint'(step_x);
			y = longint'(step_y);
			if (!second_half && b2 * x <= a2 * y) begin
				bump_x();
				if (dterm < 0) begin
					dterm += 2 * b2 * longint'(step_x) + b2;
				end else begin
					step_y--;
					dterm += 2 * b2 * longint'(step_x) - 2 * a2 * longint'(step_y) + b2;
				end
				return;
			end
			if (!second_half) begin
				// Region two seed, (x + 1/2)^2 expanded and truncated toward zero.
				second_half = 1;
				whole = b2 * (x * x + x) + a2 * (y - 1) * (y - 1) - a2 * b2 + b2 / 4;
				if (whole < 0 && (b2 % 4) != 0)
					whole += 1;
				dterm = whole;
			end
			if (dterm <= 0) begin
				bump_x();
				step_y--;
				dterm += 2 * b2 * longint'(step_x) - 2 * a2 * longint'(step_y) + a2;
			end else begin
				step_y--;
				dterm += a2 - 2 * a2 * longint'(step_y);
			end
		endfunction

		function void note_beat(logic m, logic [COORD_BITS-1:0] cx_in,
				logic [COORD_BITS-1:0] cy_in, logic [RADIUS_BITS-1:0] rx_in,
				logic [RADIUS_BITS-1:0] ry_in);
			point_t p;
			longint a2;
			if (m == MODE_START) begin
				cx = cx_in;
				cy = cy_in;
				rx = rx_in;
				ry = ry_in;
				a2 = longint'(rx) * longint'(rx);
				step_x = '0;
				step_y = ry;
				dterm = longint'(ry) * longint'(ry) - a2 * longint'(ry) + a2 / 4;
				second_half = 0;
				walking = 1;
				owe_point(plot());
			end else if (!walking) begin
				p = '0;
				owe_point(p);
			end else begin
				advance();
				owe_point(plot());
			end
		endfunction

		function void check_point(point_t seen);
			point_t want;
			if (pending_points.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected point v=%0b xp=%0d xm=%0d yp=%0d ym=%0d last=%0b",
						$realtime, seen.valid_res, $signed(seen.x_plus),
						$signed(seen.x_minus), $signed(seen.y_plus),
						$signed(seen.y_minus), seen.last);
				return;
			end
			want = pending_points.pop_front();
			if (seen !== want) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("%0t: point mismatch", $realtime);
					$display("  expected v=%0b xp=%0d xm=%0d yp=%0d ym=%0d last=%0b",
						want.valid_res, $signed(want.x_plus), $signed(want.x_minus),
						$signed(want.y_plus), $signed(want.y_minus), want.last);
					$display("  actual   v=%0b xp=%0d xm=%0d yp=%0d ym=%0d last=%0b",
						seen.valid_res, $signed(seen.x_plus), $signed(seen.x_minus),
						$signed(seen.y_plus), $signed(seen.y_minus), seen.last);
				end
			end
		endfunction
	endclass

	logic                          clk;
	logic                          arst_n;
	logic                          in_valid;
	logic                          in_stall;
	logic                          mode;
	logic [COORD_BITS-1:0]         center_x;
	logic [COORD_BITS-1:0]         center_y;
	logic [RADIUS_BITS-1:0]        radius_x;
	logic [RADIUS_BITS-1:0]        radius_y;
	logic                          out_valid;
	logic                          out_stall;
	logic                          valid_res;
	logic signed [OUT_W-1:0]       x_plus;
	logic signed [OUT_W-1:0]       x_minus;
	logic signed [OUT_W-1:0]       y_plus;
	logic signed [OUT_W-1:0]       y_minus;
	logic                          last;

	ellipse_scoreboard sb;
	point_t            seen_point;
	int                beats_sent;
	int                cycle_count;
	int                send_idle_pct;
	int                recv_stall_pct;

	midpoint_ellipse_rasterizer_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.mode      (mode),
		.center_x  (center_x),
		.center_y  (center_y),
		.radius_x  (radius_x),
		.radius_y  (radius_y),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.valid_res (valid_res),
		.x_plus    (x_plus),
		.x_minus   (x_minus),
		.y_plus    (y_plus),
		.y_minus   (y_minus),
		.last      (last)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Drop the run if it hangs; ends on the cycle the ceiling is crossed.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d points outstanding",
				cycle_count, sb.pending_points.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Receiver back-pressure: redraw the stall every falling edge.
	always @(negedge clk) begin
		out_stall = ($urandom_range(0, 99) < recv_stall_pct);
	end

	// Sample a result beat at the edge where it is taken.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen_point.valid_res = valid_res;
			seen_point.x_plus = x_plus;
			seen_point.x_minus = x_minus;
			seen_point.y_plus = y_plus;
			seen_point.y_minus = y_minus;
			seen_point.last = last;
			sb.check_point(seen_point);
		end
	end

	// Present one beat from a falling edge and hold it until it is taken.
	task automatic send_beat(logic m, logic [COORD_BITS-1:0] cx,
			logic [COORD_BITS-1:0] cy, logic [RADIUS_BITS-1:0] rx,
			logic [RADIUS_BITS-1:0] ry);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		mode = m;
		center_x = cx;
		center_y = cy;
		radius_x = rx;
		radius_y = ry;
		in_valid = 1'b1;
		do
			@(posedge clk);
		while (in_stall);
		sb.note_beat(m, cx, cy, rx, ry);
		beats_sent++;
		@(negedge clk);
	endtask

	// Step beat with random payload, which the block ignores.
	task automatic send_step();
		send_beat(MODE_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
			RADIUS_BITS'($urandom), RADIUS_BITS'($urandom));
	endtask

	// Start an ellipse, then step it until it ends or the step budget runs out.
	task automatic draw_ellipse(logic [COORD_BITS-1:0] cx, logic [COORD_BITS-1:0] cy,
			logic [RADIUS_BITS-1:0] rx, logic [RADIUS_BITS-1:0] ry, int max_steps);
		int n;
		n = 0;
		send_beat(MODE_START, cx, cy, rx, ry);
		while (sb.walking && n < max_steps) begin
			send_step();
			n++;
		end
	endtask

	// One random sequence: mostly complete small ellipses, some abandoned
	// large ones and stray steps.
	task automatic random_run();
		int unsigned            pick;
		int unsigned            span;
		int                     budget;
		logic [COORD_BITS-1:0]  cx;
		logic [COORD_BITS-1:0]  cy;
		logic [RADIUS_BITS-1:0] rx;
		logic [RADIUS_BITS-1:0] ry;
		pick = $urandom_range(0, 99);
		cx = COORD_BITS'($urandom);
		cy = COORD_BITS'($urandom);
		// Push some centers to the corners so the mirrored points wrap.
		if ($urandom_range(0, 4) == 0)
			cx = $urandom_range(0, 1) ? '1 : '0;
		if ($urandom_range(0, 4) == 0)
			cy = $urandom_range(0, 1) ? '1 : '0;
		if (pick < 6) begin
			send_step();
		end else if (pick < 16) begin
			rx = RADIUS_BITS'($urandom);
			ry = RADIUS_BITS'($urandom);
			draw_ellipse(cx, cy, rx, ry, int'($urandom_range(0, 8)));
		end else begin
			span = (pick < 26) ? 60 : 20;
			rx = RADIUS_BITS'($urandom_range(0, span));
			ry = RADIUS_BITS'($urandom_range(0, span));
			budget = ($urandom_range(0, 9) == 0) ? int'($urandom_range(1, 10)) : 1000000;
			draw_ellipse(cx, cy, rx, ry, budget);
		end
	endtask

	initial begin
		int phase_end;
		sb = new();
		beats_sent = 0;
		cycle_count = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		out_stall = 1'b0;
		mode = MODE_START;
		center_x = '0;
		center_y = '0;
		radius_x = '0;
		radius_y = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: step with nothing active, so the result is all zero.
		send_beat(MODE_STEP, '1, '1, '1, '1);
		// Zero vertical radius ends the run on its start beat.
		draw_ellipse('0, '0, '0, '0, 2);
		send_beat(MODE_STEP, '0, '0, '0, '0);
		// Largest radii at the top corner, then restart mid-run at the origin.
		draw_ellipse('1, '1, '1, '1, 3);
		draw_ellipse('0, '0, '1, '1, 2);
		// Degenerate shapes walked to the end: zero horizontal radius, flat line.
		draw_ellipse(12'd100, 12'd200, 11'd0, 11'd3, 20);
		draw_ellipse(12'd2048, 12'd2048, 11'd5, 11'd0, 2);
		// A small full ellipse crossing from region one into region two.
		draw_ellipse(12'd1000, 12'd1000, 11'd4, 11'd3, 20);

		// Random part in four pressure phases.
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 51;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 51;
				end
				default: begin
					send_idle_pct = 8;
					recv_stall_pct = 8;
				end
			endcase
			phase_end = beats_sent + RANDOM_BEATS / 4;
			while (beats_sent < phase_end)
				random_run();
		end

		// Drain: wait for every owed point, then let the block settle.
		in_valid = 1'b0;
		while (sb.pending_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.pending_points.size() != 0)
			$display("%0d expected points never arrived", sb.pending_points.size());
		if (sb.mismatches == 0 && sb.pending_points.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

/* midpoint_ellipse_rasterizer_top.f */
hw/rtl/mer_pkg.sv
hw/rtl/midpoint_ellipse_rasterizer_top.sv
dv/midpoint_ellipse_rasterizer_top_tb.sv
